// ----- rtl/core/plane_slot_lru_table_assert.svh -----
// assertion helpers for the plane slot table, clocked on clk, held off in rst
`ifndef PLANE_SLOT_LRU_TABLE_ASSERT_SVH
`define PLANE_SLOT_LRU_TABLE_ASSERT_SVH

// same-cycle implication
`define PSLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pslt check failed");

// next-cycle implication
`define PSLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pslt check failed");

`endif

// ----- rtl/core/pslt_pkg.sv -----
package pslt_pkg;

  localparam int ENTRIES     = 16;
  localparam int HEIGHT_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W     = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_JOINED   = 3'd0,
    ST_RESTART  = 3'd1,
    ST_FREE     = 3'd2,
    ST_EVICTED  = 3'd3,
    ST_DROPPED  = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // search word handed from cell to cell
  typedef struct packed {
    logic                   active;
    logic [HEIGHT_BITS-1:0] h;
    logic [TIME_BITS-1:0]   now;
    logic                   done;
    logic                   pick_valid;
    logic [IDX_W-1:0]       pick_idx;
    status_t                status;
    logic                   oldest_valid;
    logic [IDX_W-1:0]       oldest_idx;
    logic [TIME_BITS-1:0]   oldest_stamp;
  } scan_tok_t;

  // slot update broadcast to all cells
  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       idx;
    logic [HEIGHT_BITS-1:0] h;
    logic [TIME_BITS-1:0]   now;
  } slot_wr_t;

endpackage

// ----- rtl/core/pslt_cell.sv -----
module pslt_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [pslt_pkg::IDX_W-1:0] idx,
  input  pslt_pkg::scan_tok_t      tok_in,
  input  pslt_pkg::slot_wr_t       wr,
  output pslt_pkg::scan_tok_t      tok_out
);
  import pslt_pkg::*;

  logic                   valid;
  logic [HEIGHT_BITS-1:0] key;
  logic [TIME_BITS-1:0]   stamp;
  scan_tok_t              tok_next;

  // slot contents
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr.idx == idx) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == idx) begin
      key   <= wr.h;
      stamp <= wr.now;
    end
  end

  // one search step against this slot
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.done) begin
      if (!valid) begin
        if (!tok_in.pick_valid) begin
          tok_next.pick_valid = 1'b1;
          tok_next.pick_idx   = idx;
          tok_next.status     = ST_FREE;
        end
      end else if (key == tok_in.h) begin
        tok_next.done       = 1'b1;
        tok_next.pick_valid = 1'b1;
        tok_next.pick_idx   = idx;
        tok_next.status     = (stamp == tok_in.now) ? ST_JOINED : ST_RESTART;
      end else if (!tok_in.oldest_valid || stamp < tok_in.oldest_stamp) begin
        tok_next.oldest_valid = 1'b1;
        tok_next.oldest_idx   = idx;
        tok_next.oldest_stamp = stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ----- rtl/core/plane_slot_lru_table.sv -----
// channel | valid    | stall     | word
// in      | in_valid | in_stall  | req_type, height, frame_time
// out     | out_valid| out_stall | slot, status, plane_count
//
// an add walks a chain of ENTRIES slot cells, one cell per cycle with the
// accepting edge loading the first; the last cell's word is then decided
// into the pending register, and once the output is free the slot update
// and the result load happen together; the next word can follow after that
// a clear result loads in the cycle after the word is taken
// one request at a time; a result waiting on out_stall also holds in_stall
// reset (rst, synchronous) empties all slots and zeroes the count;
// a stalled result holds the update until it can be loaded
module plane_slot_lru_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  req_type,
  input  logic [15:0] height,
  input  logic [31:0] frame_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  slot,
  output logic [2:0]  status,
  output logic [15:0] plane_count
);
  import pslt_pkg::*;

  state_t                 state, state_next;
  logic                   out_free;
  logic                   in_acc;
  logic                   commit;

  scan_tok_t              tok_head;
  scan_tok_t              tok [ENTRIES+1];
  scan_tok_t              tail;
  logic [ENTRIES-1:0]     tok_act;
  slot_wr_t               wr;

  // outcome held between the end of the scan and the slot update
  logic [IDX_W-1:0]       pend_idx;
  status_t                pend_status;
  logic                   pend_start;
  logic [HEIGHT_BITS-1:0] pend_h;
  logic [TIME_BITS-1:0]   pend_now;

  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_after;

  assign out_free = !out_valid || !out_stall;
  assign in_acc   = in_valid && !in_stall;

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_acc && req_type == REQ_ADD) state_next = S_SCAN;
      S_SCAN:   if (tail.active) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    unique case (state)
      S_IDLE: begin
        in_stall = !out_free;
        commit   = 1'b0;
      end
      S_SCAN: begin
        in_stall = 1'b1;
        commit   = 1'b0;
      end
      S_FINISH: begin
        in_stall = 1'b1;
        commit   = out_free;
      end
      default: begin
        in_stall = 1'b1;
        commit   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search word entering the first cell
  always_comb begin
    tok_head        = '0;
    tok_head.active = in_acc && (req_type == REQ_ADD);
    tok_head.h      = HEIGHT_BITS'(height);
    tok_head.now    = TIME_BITS'(frame_time);
    tok_head.status = ST_FREE;
  end

  assign tok[0] = tok_head;

  assign wr.en  = commit && pend_start;
  assign wr.idx = pend_idx;
  assign wr.h   = pend_h;
  assign wr.now = pend_now;

  // the chain of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pslt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(i)),
      .tok_in  (tok[i]),
      .wr      (wr),
      .tok_out (tok[i+1])
    );
    assign tok_act[i] = tok[i+1].active;
  end

  assign tail = tok[ENTRIES];

  // decide: match or free slot, else evict the oldest unless it is current
  always_ff @(posedge clk) begin
    if (state == S_SCAN && tail.active) begin
      pend_h   <= tail.h;
      pend_now <= tail.now;
      if (tail.pick_valid) begin
        pend_idx    <= tail.pick_idx;
        pend_status <= tail.status;
        pend_start  <= (tail.status != ST_JOINED);
      end else if (tail.oldest_valid && tail.oldest_stamp != tail.now) begin
        pend_idx    <= tail.oldest_idx;
        pend_status <= ST_EVICTED;
        pend_start  <= 1'b1;
      end else begin
        pend_idx    <= '0;
        pend_status <= ST_DROPPED;
        pend_start  <= 1'b0;
      end
    end
  end

  // saturating plane count
  assign count_after = (pend_start && count != COUNT_MAX) ? count + 1'b1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc && req_type == REQ_CLEAR) begin
      count <= '0;
    end else if (commit) begin
      count <= count_after;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_acc && req_type == REQ_CLEAR) || commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && req_type == REQ_CLEAR) begin
      slot        <= '0;
      status      <= ST_CLEARED;
      plane_count <= '0;
    end else if (commit) begin
      slot        <= 4'(pend_idx);
      status      <= pend_status;
      plane_count <= count_after;
    end
  end

`include "plane_slot_lru_table_assert.svh"

  // at most one search word travels the chain
  `PSLT_ASSERT_NOW(a_one_word, 1'b1, $onehot0(tok_act))
  // the chain only finishes while the sequencer waits for it
  `PSLT_ASSERT_NOW(a_tail_in_scan, tail.active, state == S_SCAN)
  // a slot update always comes with a result load
  `PSLT_ASSERT_NEXT(a_wr_result, wr.en, out_valid && status != ST_DROPPED)
  // a clear result reports an empty count
  `PSLT_ASSERT_NOW(a_clear_zero, out_valid && status == ST_CLEARED, plane_count == '0)

endmodule

// ----- verif/plane_slot_lru_checker.sv -----
module plane_slot_lru_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [0:0]  req_type,
  input  logic [15:0] height,
  input  logic [31:0] frame_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  slot,
  input  logic [2:0]  status,
  input  logic [15:0] plane_count,
  output int          fail_count,
  output int          open_count,
  output int          checked_count,
  output int          evict_count,
  output int          drop_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pslt_pkg::*;

  typedef struct packed {
    logic [3:0]         slot;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } slot_outcome_t;

  // shadow copy of the slot table
  logic                   slot_used  [ENTRIES];
  logic [HEIGHT_BITS-1:0] slot_key   [ENTRIES];
  logic [TIME_BITS-1:0]   slot_stamp [ENTRIES];
  logic [COUNT_W-1:0]     planes;

  slot_outcome_t outcome_q[$];

  initial begin
    fail_count    = 0;
    open_count    = 0;
    checked_count = 0;
    evict_count   = 0;
    drop_count    = 0;
  end

  function automatic void clear_table();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      slot_used[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_stamp[i] = '0;
    end
    planes = '0;
  endfunction

  // scan in index order: stamped match, stale match, first empty, then lru
  function automatic slot_outcome_t place_surface(logic kind, logic [HEIGHT_BITS-1:0] key,
                                                  logic [TIME_BITS-1:0] now);
    slot_outcome_t r;
    int            i;
    int            pick;
    int            oldest;
    status_t       st;
    r.slot   = '0;
    r.status = ST_CLEARED;
    r.count  = '0;
    if (kind == REQ_CLEAR) begin
      planes = '0;
      return r;
    end
    pick   = -1;
    oldest = -1;
    st     = ST_FREE;
    for (i = 0; i < ENTRIES; i++) begin
      if (!slot_used[i]) begin
        if (pick < 0) pick = i;
      end else if (slot_key[i] == key) begin
        if (slot_stamp[i] == now) begin
          r.slot   = i[3:0];
          r.status = ST_JOINED;
          r.count  = planes;
          return r;
        end
        pick = i;
        st   = ST_RESTART;
        break;
      end else if (oldest < 0 || slot_stamp[i] < slot_stamp[oldest]) begin
        oldest = i;
      end
    end
    if (pick < 0) begin
      if (oldest < 0 || slot_stamp[oldest] == now) begin
        r.status = ST_DROPPED;
        r.count  = planes;
        return r;
      end
      pick = oldest;
      st   = ST_EVICTED;
    end
    slot_used[pick]  = 1'b1;
    slot_key[pick]   = key;
    slot_stamp[pick] = now;
    if (planes != COUNT_MAX) planes = planes + 1'b1;
    r.slot   = pick[3:0];
    r.status = st;
    r.count  = planes;
    return r;
  endfunction

  always @(posedge clk) begin
    slot_outcome_t want;
    if (rst) begin
      clear_table();
      outcome_q.delete();
      open_count <= 0;
    end else begin
      // results leave before new requests are predicted
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing expected: slot %0d status %0d count %0d",
                   $time, slot, status, plane_count);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q.pop_front();
          checked_count <= checked_count + 1;
          if (want.status == ST_EVICTED) evict_count <= evict_count + 1;
          if (want.status == ST_DROPPED) drop_count <= drop_count + 1;
          if (slot !== want.slot || status !== want.status || plane_count !== want.count) begin
            $display({"%0t: mismatch: expected slot %0d status %0d count %0d, ",
                      "got slot %0d status %0d count %0d"},
                     $time, want.slot, want.status, want.count, slot, status, plane_count);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        outcome_q.push_back(place_surface(req_type[0], height, frame_time));
      open_count <= outcome_q.size();
    end
  end

endmodule

// ----- verif/tb_plane_slot_lru_table.sv -----
module tb_plane_slot_lru_table;
  timeunit 1ns;
  timeprecision 1ps;
  import pslt_pkg::*;

  // cycles with no word moving on either side before the run is called hung
  localparam int QUIET_LIMIT = 5000;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [0:0]  req_type   = REQ_ADD;
  logic [15:0] height     = '0;
  logic [31:0] frame_time = '0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [3:0]  slot;
  logic [2:0]  status;
  logic [15:0] plane_count;

  int fail_count;
  int open_count;
  int checked_count;
  int evict_count;
  int drop_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int add_count     = 0;
  int clear_count   = 0;
  int quiet_cycles  = 0;

  // keys drawn from per phase so frames revisit the same heights
  logic [15:0] height_pool [32];
  logic [31:0] frame_now;

  plane_slot_lru_table uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .height      (height),
    .frame_time  (frame_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot        (slot),
    .status      (status),
    .plane_count (plane_count)
  );

  plane_slot_lru_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .height        (height),
    .frame_time    (frame_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot          (slot),
    .status        (status),
    .plane_count   (plane_count),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .checked_count (checked_count),
    .evict_count   (evict_count),
    .drop_count    (drop_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // hang detector: resets whenever a word moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("plane_slot_lru_table test failed");
        $finish;
      end
    end
  end

  // present one word and hold it until the block takes it; random idle
  // cycles go in front, one valid drop per cycle at most
  task automatic send_word(input logic kind, input logic [15:0] key, input logic [31:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    height     <= key;
    frame_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == REQ_CLEAR) clear_count++;
    else add_count++;
  endtask

  // sender holds off until every result in flight has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic refill_pool();
    int i;
    for (i = 0; i < 32; i++) height_pool[i] = 16'($urandom);
    frame_now = $urandom;
  endtask

  // frame-shaped traffic: a frame stamp, then a burst of adds over a pool
  // window that is sometimes wider than the table (evictions and drops),
  // plus stray clears and random noise words
  task automatic run_frames(input int n_items);
    int sent;
    int roll;
    int width;
    int burst;
    int k;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_word(REQ_CLEAR, 16'($urandom), $urandom);
        sent++;
      end else if (roll < 13) begin
        send_word(REQ_ADD, 16'($urandom), $urandom);
        sent++;
      end else begin
        roll = $urandom_range(0, 19);
        if (roll == 0) frame_now = $urandom;
        else if (roll != 1) frame_now = frame_now + $urandom_range(1, 3);
        width = $urandom_range(4, 32);
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst; k++) begin
          send_word(REQ_ADD, height_pool[5'($urandom_range(0, width - 1))], frame_now);
          sent++;
        end
      end
    end
  endtask

  // fixed opening sequence over the corner cases
  task automatic directed_words();
    int k;
    send_word(REQ_ADD, 16'h0000, 32'h0000_0000);     // empty table: free slot 0
    send_word(REQ_ADD, 16'h0000, 32'h0000_0000);     // same key, same frame: joins
    send_word(REQ_ADD, 16'hffff, 32'hffff_ffff);     // extremes into slot 1
    send_word(REQ_ADD, 16'h0000, 32'h0000_0001);     // stale match restarts
    send_word(REQ_CLEAR, 16'hffff, 32'hffff_ffff);   // clear ignores key and stamp
    for (k = 1; k <= 14; k++)
      send_word(REQ_ADD, k[15:0], 32'h0000_0005);    // fill the rest of the table
    send_word(REQ_ADD, 16'h0100, 32'h0000_0005);     // full: evict oldest stamp
    send_word(REQ_ADD, 16'h0101, 32'h0000_0005);     // oldest used this frame: drop
    send_word(REQ_ADD, 16'h0102, 32'hffff_ffff);     // tie on oldest, lowest index goes
    send_word(REQ_ADD, 16'h000e, 32'h0000_0006);     // stale match at the last slot
    send_word(REQ_CLEAR, 16'h0000, 32'h0000_0000);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // slow receiver
    send_idle_pct = 30;
    recv_idle_pct = 65;
    refill_pool();
    directed_words();
    run_frames(520);
    drain();

    // slow sender
    send_idle_pct = 65;
    recv_idle_pct = 30;
    refill_pool();
    run_frames(550);
    drain();

    // full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    refill_pool();
    run_frames(550);
    drain();

    // trailing cycles in case anything stray comes out
    repeat (ENTRIES + 8) @(posedge clk);

    $display("covered %0d adds and %0d clears under three idle mixes",
             add_count, clear_count);
    $display("%0d results checked, %0d evictions, %0d drops, %0d failures",
             checked_count, evict_count, drop_count, fail_count);
    if (fail_count == 0) begin
      $display("plane_slot_lru_table test passed");
    end else begin
      $display("plane_slot_lru_table test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pslt_pkg.sv
rtl/core/pslt_cell.sv
rtl/core/plane_slot_lru_table.sv
verif/plane_slot_lru_checker.sv
verif/tb_plane_slot_lru_table.sv
